[rtl/core/fbpa_pkg.sv]
package fbpa_pkg;

	// Field widths
	localparam int MODE_W    = 2;
	localparam int REQ_W     = 32;
	localparam int OFF_W     = 24;
	localparam int SIZE_W    = 17;
	localparam int COUNT_W   = 9;
	localparam int ID_W      = 16;
	localparam int STATUS_W  = 3;
	localparam int BYTES_W   = 25;
	localparam int TOTAL_W   = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 17;

	// Operation codes
	localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RESET = 2'd2;
	localparam logic [MODE_W-1:0] MODE_STATS = 2'd3;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_SIZE = 3'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ALLOCATOR_ID = 2'd2;

	// Register reset values and limits
	localparam logic [SIZE_W-1:0]  BLOCK_SIZE_RST  = 17'd64;
	localparam logic [COUNT_W-1:0] BLOCK_COUNT_RST = 9'd256;
	localparam logic [ID_W-1:0]    ALLOC_ID_RST    = 16'd1;
	localparam logic [SIZE_W-1:0]  SIZE_CAP        = 17'd65536;

endpackage

[rtl/core/fbpa_div.sv]
module fbpa_div
	import fbpa_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [OFF_W-1:0] dividend,
	input  logic [SIZE_W-1:0] divisor,
	output logic             done,
	output logic [OFF_W-1:0] quotient
);

	localparam int STEP_W = $clog2(OFF_W);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(OFF_W - 1);

	logic              run_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [SIZE_W-1:0] rem_q;
	logic [OFF_W-1:0]  quo_q;
	logic [SIZE_W-1:0] divisor_q;

	logic [SIZE_W:0]   shifted;
	logic              take;
	logic [SIZE_W-1:0] rem_next;

	// Trial subtract of one quotient bit
	always_comb begin
		shifted  = {rem_q, quo_q[OFF_W-1]};
		take     = (shifted >= {1'b0, divisor_q});
		rem_next = take ? SIZE_W'(shifted - {1'b0, divisor_q}) : shifted[SIZE_W-1:0];
	end

	// Sequence one restoring step per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == LAST_STEP) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Hold operands and partial results
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q     <= '0;
			quo_q     <= dividend;
			divisor_q <= divisor;
		end else if (run_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[OFF_W-2:0], take};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[rtl/core/fbpa_stack.sv]
module fbpa_stack #(
	parameter int DEPTH = 256,
	parameter int IW    = 8
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [IW-1:0] wr_addr,
	input  logic [IW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [IW-1:0] rd_addr,
	output logic [IW-1:0] rd_data
);

	logic [IW-1:0] mem [DEPTH];
	logic [IW-1:0] rd_data_q;

	// Write one entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Register the read data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[rtl/core/fixed_block_pool_allocator.sv]
// Fixed-size block pool allocator with a LIFO stack of free block indices.
// Issue an operation by raising start while busy is low; the result appears
// for exactly one cycle with done high and must be captured then. A granted
// allocate steps through S_POP, S_GRANT, S_PEAK, S_CAP and S_OUT. Statistics
// and any operation rejected before the divider go through S_CAP and S_OUT.
// A free that reaches the divider takes one quotient bit a cycle for all 24
// offset bits, then checks the index and reports through S_CAP and S_OUT.
// Reset pool refills the stack memory one entry a cycle, then reports through S_CAP and S_OUT.
// One shared multiplier forms the grant offset, the peak and the capacity in
// turn. After reset the block runs a refill pass of min(256, MAX_BLOCKS)
// entries with busy high and no result; configuration writes are taken at any
// time, but must only be issued while the block is idle.
module fixed_block_pool_allocator
	import fbpa_pkg::*;
#(
	parameter int MAX_BLOCKS = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [MODE_W-1:0]    mode,
	input  logic [REQ_W-1:0]     request_size,
	input  logic [OFF_W-1:0]     handle_offset,
	input  logic                 handle_valid,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	output logic                 done,
	output logic [STATUS_W-1:0]  status,
	output logic [OFF_W-1:0]     grant_offset,
	output logic [SIZE_W-1:0]    grant_size,
	output logic [ID_W-1:0]      grant_owner,
	output logic [COUNT_W-1:0]   used_blocks,
	output logic [BYTES_W-1:0]   peak_bytes,
	output logic [TOTAL_W-1:0]   alloc_total,
	output logic [TOTAL_W-1:0]   free_total,
	output logic [BYTES_W-1:0]   capacity_bytes,
	output logic [SIZE_W-1:0]    largest_free
);

	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam int IW = $clog2(MAX_BLOCKS);
	localparam int PW = (CW + SIZE_W > BYTES_W) ? CW + SIZE_W : BYTES_W;
	localparam int FILL_RST = (MAX_BLOCKS < int'(BLOCK_COUNT_RST)) ?
		MAX_BLOCKS : int'(BLOCK_COUNT_RST);

	typedef enum logic [2:0] {
		S_IDLE,
		S_REFILL,
		S_DIV,
		S_POP,
		S_GRANT,
		S_PEAK,
		S_CAP,
		S_OUT
	} state_t;

	state_t               state_q;
	logic                 init_q;
	logic [SIZE_W-1:0]    block_size_q;
	logic [COUNT_W-1:0]   block_count_q;
	logic [ID_W-1:0]      allocator_id_q;
	logic [CW-1:0]        top_q;
	logic [CW-1:0]        fill_cnt_q;
	logic [CW-1:0]        fill_n_q;
	logic [PW-1:0]        prod_q;
	logic [PW-1:0]        peak_q;
	logic [TOTAL_W-1:0]   alloc_cnt_q;
	logic [TOTAL_W-1:0]   free_cnt_q;
	logic                 done_q;
	logic [STATUS_W-1:0]  status_q;
	logic [OFF_W-1:0]     grant_offset_q;
	logic [SIZE_W-1:0]    grant_size_q;
	logic [ID_W-1:0]      grant_owner_q;
	logic [COUNT_W-1:0]   used_q;
	logic [BYTES_W-1:0]   capacity_q;
	logic [SIZE_W-1:0]    largest_q;

	logic [SIZE_W-1:0]    bs;
	logic [CW-1:0]        bc;
	logic [CW-1:0]        used;
	logic                 accept;
	logic                 div_start;
	logic                 div_done;
	logic [OFF_W-1:0]     quot;
	logic                 idx_ok;
	logic                 free_ok;
	logic                 fill_more;
	logic [CW-1:0]        mul_a;
	logic                 wr_en;
	logic [IW-1:0]        wr_addr;
	logic [IW-1:0]        wr_data;
	logic                 rd_en;
	logic [IW-1:0]        rd_addr;
	logic [IW-1:0]        rd_data;

	// Clamp the configuration to its working range
	always_comb begin
		bs = (block_size_q > SIZE_CAP) ? SIZE_CAP : block_size_q;
		bc = (32'(block_count_q) > 32'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : CW'(block_count_q);
		used = (bc > top_q) ? CW'(bc - top_q) : '0;
	end

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign div_start = accept && (mode == MODE_FREE) && handle_valid && (bs != '0);

	// Free checks on the quotient
	assign idx_ok    = (quot < {{(OFF_W - CW){1'b0}}, bc});
	assign free_ok   = idx_ok && (top_q < bc);
	assign fill_more = (fill_cnt_q < fill_n_q);

	// Stack port selection
	always_comb begin
		wr_en   = ((state_q == S_REFILL) && fill_more) ||
			((state_q == S_DIV) && div_done && free_ok);
		wr_addr = (state_q == S_REFILL) ? fill_cnt_q[IW-1:0] : top_q[IW-1:0];
		wr_data = (state_q == S_REFILL) ? IW'(fill_n_q - fill_cnt_q - 1'b1) : quot[IW-1:0];
		rd_en   = accept && (mode == MODE_ALLOC);
		rd_addr = IW'(top_q - 1'b1);
	end

	// Select the multiplier operand
	always_comb begin
		case (state_q)
			S_POP:   mul_a = CW'(rd_data);
			S_GRANT: mul_a = used;
			default: mul_a = bc;
		endcase
	end

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q   <= BLOCK_SIZE_RST;
			block_count_q  <= BLOCK_COUNT_RST;
			allocator_id_q <= ALLOC_ID_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_BLOCK_SIZE:   block_size_q   <= cfg_data[SIZE_W-1:0];
				CFG_BLOCK_COUNT:  block_count_q  <= cfg_data[COUNT_W-1:0];
				CFG_ALLOCATOR_ID: allocator_id_q <= cfg_data[ID_W-1:0];
				default: ;
			endcase
		end
	end

	// Shared multiplier, one product a cycle
	always_ff @(posedge clk) begin
		prod_q <= PW'({{(PW - CW){1'b0}}, mul_a} * {{(PW - SIZE_W){1'b0}}, bs});
	end

	// Sequencer with registered results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_REFILL;
			init_q         <= 1'b1;
			top_q          <= '0;
			fill_cnt_q     <= '0;
			fill_n_q       <= CW'(FILL_RST);
			peak_q         <= '0;
			alloc_cnt_q    <= '0;
			free_cnt_q     <= '0;
			done_q         <= 1'b0;
			status_q       <= ST_OK;
			grant_offset_q <= '0;
			grant_size_q   <= '0;
			grant_owner_q  <= '0;
			used_q         <= '0;
			capacity_q     <= '0;
			largest_q      <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						status_q       <= ST_OK;
						grant_offset_q <= '0;
						grant_size_q   <= '0;
						grant_owner_q  <= '0;
						case (mode)
							MODE_ALLOC: begin
								if ((request_size == '0) ||
									(request_size > {{(REQ_W - SIZE_W){1'b0}}, bs})) begin
									status_q <= ST_BAD_SIZE;
									state_q  <= S_CAP;
								end else if (top_q == '0) begin
									status_q <= ST_EMPTY;
									state_q  <= S_CAP;
								end else begin
									top_q       <= top_q - 1'b1;
									alloc_cnt_q <= alloc_cnt_q + 1'b1;
									state_q     <= S_POP;
								end
							end
							MODE_FREE: begin
								if (div_start) begin
									state_q <= S_DIV;
								end else begin
									status_q <= ST_INVALID;
									state_q  <= S_CAP;
								end
							end
							MODE_RESET: begin
								fill_cnt_q <= '0;
								fill_n_q   <= bc;
								state_q    <= S_REFILL;
							end
							default: begin
								state_q <= S_CAP;
							end
						endcase
					end
				end
				S_REFILL: begin
					if (fill_more) begin
						fill_cnt_q <= fill_cnt_q + 1'b1;
					end else begin
						top_q  <= fill_n_q;
						init_q <= 1'b0;
						state_q <= init_q ? S_IDLE : S_CAP;
					end
				end
				S_DIV: begin
					if (div_done) begin
						if (!idx_ok) begin
							status_q <= ST_INVALID;
						end else if (!free_ok) begin
							status_q <= ST_FULL;
						end else begin
							top_q      <= top_q + 1'b1;
							free_cnt_q <= free_cnt_q + 1'b1;
						end
						state_q <= S_CAP;
					end
				end
				S_POP: begin
					state_q <= S_GRANT;
				end
				S_GRANT: begin
					grant_offset_q <= prod_q[OFF_W-1:0];
					grant_size_q   <= bs;
					grant_owner_q  <= allocator_id_q;
					state_q        <= S_PEAK;
				end
				S_PEAK: begin
					if (prod_q > peak_q) begin
						peak_q <= prod_q;
					end
					state_q <= S_CAP;
				end
				S_CAP: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					capacity_q <= prod_q[BYTES_W-1:0];
					used_q     <= COUNT_W'(used);
					largest_q  <= (top_q != '0) ? bs : '0;
					done_q     <= 1'b1;
					state_q    <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	fbpa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (handle_offset),
		.divisor  (bs),
		.done     (div_done),
		.quotient (quot)
	);

	fbpa_stack #(
		.DEPTH (MAX_BLOCKS),
		.IW    (IW)
	) u_stack (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign done           = done_q;
	assign status         = status_q;
	assign grant_offset   = grant_offset_q;
	assign grant_size     = grant_size_q;
	assign grant_owner    = grant_owner_q;
	assign used_blocks    = used_q;
	assign peak_bytes     = peak_q[BYTES_W-1:0];
	assign alloc_total    = alloc_cnt_q;
	assign free_total     = free_cnt_q;
	assign capacity_bytes = capacity_q;
	assign largest_free   = largest_q;

endmodule

[rtl/core/fbpa_checker.sv]
module fbpa_props
	import fbpa_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                done,
	input logic [STATUS_W-1:0] status,
	input logic [OFF_W-1:0]    grant_offset,
	input logic [SIZE_W-1:0]   grant_size,
	input logic [ID_W-1:0]     grant_owner,
	input logic [SIZE_W-1:0]   largest_free
);

	// An accepted transfer occupies the block
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("block not busy after an accepted transfer");

	// A result only follows work in progress
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without preceding work");

	// The result strobe lasts one cycle
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// A failed operation grants nothing
	a_fail_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != ST_OK)) |->
		((grant_offset == '0) && (grant_size == '0) && (grant_owner == '0)))
		else $error("grant fields set on a failed operation");

	// An empty pool reports no free block
	a_empty_no_free: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == ST_EMPTY)) |-> (largest_free == '0))
		else $error("free block reported with an empty pool");

endmodule

bind fixed_block_pool_allocator fbpa_props u_fbpa_props (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.status       (status),
	.grant_offset (grant_offset),
	.grant_size   (grant_size),
	.grant_owner  (grant_owner),
	.largest_free (largest_free)
);

[sim/fbpa_checker.sv]
module fbpa_checker
	import fbpa_pkg::*;
#(
	parameter int POOL_DEPTH = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  logic [MODE_W-1:0]    mode,
	input  logic [REQ_W-1:0]     request_size,
	input  logic [OFF_W-1:0]     handle_offset,
	input  logic                 handle_valid,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	input  logic                 done,
	input  logic [STATUS_W-1:0]  status,
	input  logic [OFF_W-1:0]     grant_offset,
	input  logic [SIZE_W-1:0]    grant_size,
	input  logic [ID_W-1:0]      grant_owner,
	input  logic [COUNT_W-1:0]   used_blocks,
	input  logic [BYTES_W-1:0]   peak_bytes,
	input  logic [TOTAL_W-1:0]   alloc_total,
	input  logic [TOTAL_W-1:0]   free_total,
	input  logic [BYTES_W-1:0]   capacity_bytes,
	input  logic [SIZE_W-1:0]    largest_free,
	output int                   mismatches,
	output int                   pending
);

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [OFF_W-1:0]    grant_offset;
		logic [SIZE_W-1:0]   grant_size;
		logic [ID_W-1:0]     grant_owner;
		logic [COUNT_W-1:0]  used_blocks;
		logic [BYTES_W-1:0]  peak_bytes;
		logic [TOTAL_W-1:0]  alloc_total;
		logic [TOTAL_W-1:0]  free_total;
		logic [BYTES_W-1:0]  capacity_bytes;
		logic [SIZE_W-1:0]   largest_free;
	} pool_reply_t;

	// Shadow copy of the pool registers and state
	logic [SIZE_W-1:0]  cur_block_size;
	logic [COUNT_W-1:0] cur_block_count;
	logic [ID_W-1:0]    cur_owner_id;
	int unsigned        free_idx [POOL_DEPTH];
	int unsigned        free_top_n;
	longint unsigned    peak_q;
	logic [TOTAL_W-1:0] grants_made;
	logic [TOTAL_W-1:0] frees_taken;

	pool_reply_t reply_q [$];
	int          errors = 0;

	// Block size as the pool uses it, capped at the largest legal block
	function automatic longint unsigned live_block_size();
		return (cur_block_size > SIZE_CAP) ? longint'(SIZE_CAP) : longint'(cur_block_size);
	endfunction

	// Block count as the pool uses it, capped at the stack depth
	function automatic longint unsigned live_block_count();
		return (cur_block_count > POOL_DEPTH) ? longint'(POOL_DEPTH) : longint'(cur_block_count);
	endfunction

	// Rebuild the free stack with index 0 on top
	function automatic void refill_free_stack();
		int unsigned n;
		n = int'(live_block_count());
		for (int unsigned i = 0; i < n; i++)
			free_idx[i] = n - 1 - i;
		free_top_n = n;
	endfunction

	// Apply one pool operation to the shadow state and form its reply
	function automatic pool_reply_t apply_pool_op(logic [MODE_W-1:0] op, logic [REQ_W-1:0] req,
		logic [OFF_W-1:0] off, logic hval);
		pool_reply_t     r;
		longint unsigned bs;
		longint unsigned bc;
		longint unsigned used;
		longint unsigned idx;
		bs = live_block_size();
		bc = live_block_count();
		r.status       = ST_OK;
		r.grant_offset = '0;
		r.grant_size   = '0;
		r.grant_owner  = '0;
		case (op)
			MODE_ALLOC: begin
				if (req == 0 || req > bs) begin
					r.status = ST_BAD_SIZE;
				end else if (free_top_n == 0) begin
					r.status = ST_EMPTY;
				end else begin
					free_top_n--;
					idx = free_idx[free_top_n];
					grants_made++;
					used = (bc > free_top_n) ? bc - free_top_n : 0;
					if (used * bs > peak_q)
						peak_q = used * bs;
					r.grant_offset = OFF_W'(idx * bs);
					r.grant_size   = SIZE_W'(bs);
					r.grant_owner  = cur_owner_id;
				end
			end
			MODE_FREE: begin
				if (!hval || bs == 0) begin
					r.status = ST_INVALID;
				end else begin
					idx = off / bs;
					if (idx >= bc) begin
						r.status = ST_INVALID;
					end else if (free_top_n >= bc) begin
						r.status = ST_FULL;
					end else begin
						free_idx[free_top_n] = int'(idx);
						free_top_n++;
						frees_taken++;
					end
				end
			end
			MODE_RESET: refill_free_stack();
			MODE_STATS: ;
			default: ;
		endcase
		used = (bc > free_top_n) ? bc - free_top_n : 0;
		r.used_blocks    = COUNT_W'(used);
		r.peak_bytes     = BYTES_W'(peak_q);
		r.alloc_total    = grants_made;
		r.free_total     = frees_taken;
		r.capacity_bytes = BYTES_W'(bc * bs);
		r.largest_free   = (free_top_n > 0) ? SIZE_W'(bs) : '0;
		return r;
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
		end
	endtask

	// Track register transfers, compare replies, then queue the prediction for a new command
	always @(posedge clk or negedge arst_n) begin : track
		pool_reply_t want;
		if (!arst_n) begin
			cur_block_size  = BLOCK_SIZE_RST;
			cur_block_count = BLOCK_COUNT_RST;
			cur_owner_id    = ALLOC_ID_RST;
			peak_q          = 0;
			grants_made     = '0;
			frees_taken     = '0;
			refill_free_stack();
			reply_q.delete();
			pending    <= 0;
			mismatches <= errors;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_BLOCK_SIZE:   cur_block_size  = cfg_data[SIZE_W-1:0];
					CFG_BLOCK_COUNT:  cur_block_count = cfg_data[COUNT_W-1:0];
					CFG_ALLOCATOR_ID: cur_owner_id    = cfg_data[ID_W-1:0];
					default: ;
				endcase
			end
			if (done) begin
				if (reply_q.size() == 0) begin
					errors++;
					$display("%0t: reply with none outstanding, expected no reply actual status %0h",
						$time, status);
				end else begin
					want = reply_q.pop_front();
					check_field("status", 32'(want.status), 32'(status));
					check_field("grant_offset", 32'(want.grant_offset), 32'(grant_offset));
					check_field("grant_size", 32'(want.grant_size), 32'(grant_size));
					check_field("grant_owner", 32'(want.grant_owner), 32'(grant_owner));
					check_field("used_blocks", 32'(want.used_blocks), 32'(used_blocks));
					check_field("peak_bytes", 32'(want.peak_bytes), 32'(peak_bytes));
					check_field("alloc_total", want.alloc_total, alloc_total);
					check_field("free_total", want.free_total, free_total);
					check_field("capacity_bytes", 32'(want.capacity_bytes), 32'(capacity_bytes));
					check_field("largest_free", 32'(want.largest_free), 32'(largest_free));
				end
			end
			// Append the prediction behind those still outstanding
			if (start && !busy)
				reply_q.insert(reply_q.size(),
					apply_pool_op(mode, request_size, handle_offset, handle_valid));
			pending    <= reply_q.size();
			mismatches <= errors;
		end
	end

endmodule

[sim/tb_fixed_block_pool_allocator.sv]
module tb_fixed_block_pool_allocator;
	import fbpa_pkg::*;

	localparam int POOL_DEPTH    = 256;
	localparam int STALL_LIMIT   = 4000;
	localparam int DRAIN_CYCLES  = 40;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_ITEMS   = 65;
	localparam int MAX_GAP       = 14;

	// Register index with no register behind it
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 start         = 1'b0;
	logic                 busy;
	logic [MODE_W-1:0]    mode          = MODE_STATS;
	logic [REQ_W-1:0]     request_size  = '0;
	logic [OFF_W-1:0]     handle_offset = '0;
	logic                 handle_valid  = 1'b0;
	logic                 cfg_valid     = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index     = CFG_BLOCK_SIZE;
	logic [CFG_DAT_W-1:0] cfg_data      = '0;
	logic                 done;
	logic [STATUS_W-1:0]  status;
	logic [OFF_W-1:0]     grant_offset;
	logic [SIZE_W-1:0]    grant_size;
	logic [ID_W-1:0]      grant_owner;
	logic [COUNT_W-1:0]   used_blocks;
	logic [BYTES_W-1:0]   peak_bytes;
	logic [TOTAL_W-1:0]   alloc_total;
	logic [TOTAL_W-1:0]   free_total;
	logic [BYTES_W-1:0]   capacity_bytes;
	logic [SIZE_W-1:0]    largest_free;
	int                   mismatches;
	int                   pending;

	int          stall_cycles = 0;
	bit          burst        = 1'b0;
	int unsigned stim_size    = 64;
	int unsigned stim_count   = 256;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	fixed_block_pool_allocator #(
		.MAX_BLOCKS(POOL_DEPTH)
	) DUT (.*);

	fbpa_checker #(
		.POOL_DEPTH(POOL_DEPTH)
	) u_checker (.*);

	// Issue one command, maybe idling first if not in a burst; hold it until the transfer
	task automatic run_op(logic [MODE_W-1:0] op, logic [REQ_W-1:0] req,
		logic [OFF_W-1:0] off, logic hval);
		int gap;
		gap = burst ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start         <= 1'b1;
		mode          <= op;
		request_size  <= req;
		handle_offset <= off;
		handle_valid  <= hval;
		do @(posedge clk); while (busy);
	endtask

	// Drop start and wait until every reply is in and the block is free
	task automatic wait_idle();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0 || busy);
	endtask

	// Write one register; keep valid up when another write follows
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] dat, bit last);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= dat;
		do @(posedge clk); while (!cfg_ready);
		if (last)
			cfg_valid <= 1'b0;
	endtask

	// Reprogramme the pool while idle; unused data bits carry noise
	task automatic set_pool(int unsigned bsize, int unsigned bcount, int unsigned owner,
		bit spare);
		logic [CFG_DAT_W-1:0] d;
		wait_idle();
		write_reg(CFG_BLOCK_SIZE, CFG_DAT_W'(bsize), 1'b0);
		d = CFG_DAT_W'($urandom());
		d[COUNT_W-1:0] = bcount[COUNT_W-1:0];
		write_reg(CFG_BLOCK_COUNT, d, 1'b0);
		d = CFG_DAT_W'($urandom());
		d[ID_W-1:0] = owner[ID_W-1:0];
		write_reg(CFG_ALLOCATOR_ID, d, !spare);
		if (spare)
			write_reg(CFG_UNUSED, CFG_DAT_W'($urandom()), 1'b1);
		stim_size  = (bsize[SIZE_W-1:0] > SIZE_CAP) ? SIZE_CAP : bsize[SIZE_W-1:0];
		stim_count = (bcount[COUNT_W-1:0] > POOL_DEPTH) ? POOL_DEPTH : bcount[COUNT_W-1:0];
	endtask

	// Mostly legal allocates and frees of real blocks, with some noise
	task automatic random_op();
		int unsigned pick;
		int unsigned sz;
		int unsigned idx;
		pick = $urandom_range(0, 99);
		sz   = (stim_size == 0) ? 1 : stim_size;
		idx  = (stim_count == 0) ? 0 : $urandom_range(0, stim_count - 1);
		if (pick < 40)
			run_op(MODE_ALLOC, $urandom_range(1, sz), OFF_W'($urandom()), 1'($urandom()));
		else if (pick < 70)
			run_op(MODE_FREE, $urandom(), OFF_W'(idx * sz + $urandom_range(0, sz - 1)), 1'b1);
		else if (pick < 76)
			run_op(MODE_RESET, $urandom(), OFF_W'($urandom()), 1'($urandom()));
		else if (pick < 84)
			run_op(MODE_STATS, $urandom(), OFF_W'($urandom()), 1'($urandom()));
		else
			run_op(MODE_W'($urandom()), $urandom(), OFF_W'($urandom()), 1'($urandom()));
	endtask

	function automatic int unsigned pick_size();
		int unsigned r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return 0;
		if (r == 1)
			return $urandom_range(65537, 131071);
		if (r < 12)
			return $urandom_range(1, 256);
		return $urandom_range(1, 65536);
	endfunction

	function automatic int unsigned pick_count();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 0;
		if (r == 1)
			return $urandom_range(257, 511);
		if (r < 7)
			return $urandom_range(1, 8);
		return $urandom_range(1, 256);
	endfunction

	// Stimulus and verdict
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Default pool: size limits, a grant pair, each kind of rejected free
		run_op(MODE_STATS, '0, '0, 1'b0);
		run_op(MODE_ALLOC, 32'd0, '0, 1'b0);
		run_op(MODE_ALLOC, 32'hFFFF_FFFF, '0, 1'b0);
		run_op(MODE_ALLOC, 32'd65, '0, 1'b0);
		run_op(MODE_ALLOC, 32'd64, '0, 1'b0);
		run_op(MODE_ALLOC, 32'd1, '0, 1'b0);
		run_op(MODE_FREE, '0, 24'd64, 1'b0);
		run_op(MODE_FREE, '0, 24'hFF_FFFF, 1'b1);
		run_op(MODE_FREE, '0, 24'd65, 1'b1);
		run_op(MODE_FREE, '0, 24'd0, 1'b1);
		run_op(MODE_FREE, '0, 24'd128, 1'b1);

		// Zero block size: nothing can be granted or freed
		set_pool(0, 3, 16'hA5A5, 1'b0);
		run_op(MODE_ALLOC, 32'd1, '0, 1'b0);
		run_op(MODE_FREE, '0, 24'd0, 1'b1);
		run_op(MODE_RESET, '0, '0, 1'b0);
		run_op(MODE_STATS, '0, '0, 1'b0);

		// Oversized block with a zero count: the pool is empty after its rebuild
		set_pool(131071, 0, 16'hFFFF, 1'b1);
		run_op(MODE_ALLOC, 32'd65536, '0, 1'b0);
		run_op(MODE_RESET, '0, '0, 1'b0);
		run_op(MODE_ALLOC, 32'd65536, '0, 1'b0);
		run_op(MODE_FREE, '0, 24'd0, 1'b1);

		// Single one-byte block: empty and full stack
		set_pool(1, 1, 1, 1'b0);
		run_op(MODE_RESET, '0, '0, 1'b0);
		run_op(MODE_ALLOC, 32'd1, '0, 1'b0);
		run_op(MODE_ALLOC, 32'd1, '0, 1'b0);
		run_op(MODE_FREE, '0, 24'd0, 1'b1);
		run_op(MODE_FREE, '0, 24'd0, 1'b1);

		// Random phases, each under its own pool setting
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0: set_pool(1, 1, 16'hFFFF, 1'b0);
				1: set_pool(65536, 256, 1, 1'b1);
				2: set_pool(131071, 511, $urandom(), 1'b0);
				default: set_pool(pick_size(), pick_count(), $urandom(), 1'($urandom()));
			endcase
			burst = (ph % 3 == 2);
			if ($urandom_range(0, 3) != 0)
				run_op(MODE_RESET, $urandom(), OFF_W'($urandom()), 1'($urandom()));
			repeat (PHASE_ITEMS) random_op();
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Watchdog: count cycles with no transfer on any channel
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

endmodule

[sim.f]
rtl/core/fbpa_pkg.sv
rtl/core/fbpa_div.sv
rtl/core/fbpa_stack.sv
rtl/core/fixed_block_pool_allocator.sv
rtl/core/fbpa_checker.sv
sim/fbpa_checker.sv
sim/tb_fixed_block_pool_allocator.sv
